// ===== rtl/bsfm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsfm_pkg
// Shared widths, operation codes and controller/datapath link types of the
// byte stack with frame marks.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfm_pkg;

	// Field widths of the request and result channels
	localparam int KIND_W  = 3;
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 17;
	localparam int SIZE_W  = 17;
	localparam int DEPTH_W = 9;

	// Default sizing
	localparam int DEF_STACK_BYTES = 65536;
	localparam int DEF_MARK_DEPTH  = 256;
	localparam int DEF_MAX_POP_OUT = 64;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_MARK    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_BACK    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RESERVE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_POP     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd5;

	// Controller to datapath commands
	typedef struct packed {
		logic mark;       // save pointer on the mark stack
		logic back_zero;  // back with no mark stored
		logic back_rd;    // read the top mark
		logic back_fin;   // restore pointer from the mark read
		logic push;       // write one byte
		logic reserve;    // advance pointer
		logic pop_start;  // lower pointer, issue first byte read
		logic clear;      // empty both stacks
		logic status_ld;  // load a status result into the output register
		logic pop_ld;     // load a popped byte into the output register
	} bsfm_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic marks_empty;
		logic pop_last;
	} bsfm_status_t;

endpackage

`default_nettype wire

// ===== rtl/bsfm_if.sv =====
// ----------------------------------------------------------------------------
// bsfm channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsfm_item_if
	import bsfm_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] data_byte;
	logic [LEN_W-1:0]  length;
	logic              first_of_push;

	modport source (output valid, kind, data_byte, length, first_of_push, input ready);
	modport sink   (input valid, kind, data_byte, length, first_of_push, output ready);
endinterface

interface bsfm_result_if
	import bsfm_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  out_byte;
	logic               byte_valid;
	logic               last;
	logic [SIZE_W-1:0]  stack_size;
	logic [DEPTH_W-1:0] mark_depth;

	modport source (output valid, out_byte, byte_valid, last, stack_size, mark_depth,
		input ready);
	modport sink   (input valid, out_byte, byte_valid, last, stack_size, mark_depth,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/byte_stack_with_frame_marks_top.sv =====
// A status result is valid in the cycle after its request; a back with a mark reads it first.
// Pop: bytes read, then registered; one byte per cycle unless stalled (min(length, MAX_POP_OUT)).
// Throughput: mark, push, reserve, clear: one request per cycle; a full output register stalls it.
// Pop holds off new requests until its last byte leaves; back blocks for its mark read.
// Reset: stack pointer and mark count clear at once; byte and mark memories are not cleared.
// ----------------------------------------------------------------------------
// byte_stack_with_frame_marks_top
// Byte stack with a separate stack of frame marks.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stack_with_frame_marks_top
	import bsfm_pkg::*;
#(
	parameter int STACK_BYTES = DEF_STACK_BYTES,
	parameter int MARK_DEPTH  = DEF_MARK_DEPTH,
	parameter int MAX_POP_OUT = DEF_MAX_POP_OUT
) (
	input  logic          clk,
	input  logic          arst_n,
	bsfm_item_if.sink     item,
	bsfm_result_if.source result
);

	bsfm_cmd_t    cmd;
	bsfm_status_t status;
	logic         in_ready;
	logic         out_valid;

	assign item.ready   = in_ready;
	assign result.valid = out_valid;

	bsfm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (in_ready),
		.in_kind   (item.kind),
		.len_zero  (item.length == '0),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	bsfm_datapath #(
		.STACK_BYTES (STACK_BYTES),
		.MARK_DEPTH  (MARK_DEPTH),
		.MAX_POP_OUT (MAX_POP_OUT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.in_data_byte     (item.data_byte),
		.in_length        (item.length),
		.in_first_of_push (item.first_of_push),
		.out_byte         (result.out_byte),
		.out_byte_valid   (result.byte_valid),
		.out_last         (result.last),
		.out_stack_size   (result.stack_size),
		.out_mark_depth   (result.mark_depth)
	);

endmodule

`default_nettype wire

// ===== rtl/bsfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsfm_ctrl
// Controller: request decode, back and pop sequencing, output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfm_ctrl
	import bsfm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KIND_W-1:0] in_kind,
	input  logic              len_zero,
	output logic              out_valid,
	input  logic              out_ready,
	input  bsfm_status_t      status,
	output bsfm_cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BACK = 2'd1;
	localparam logic [1:0] ST_POP  = 2'd2;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_kind)
						KIND_MARK: begin
							cmd.mark      = 1'b1;
							cmd.status_ld = 1'b1;
						end
						KIND_BACK: begin
							if (status.marks_empty) begin
								cmd.back_zero = 1'b1;
								cmd.status_ld = 1'b1;
							end else begin
								cmd.back_rd = 1'b1;
								state_d     = ST_BACK;
							end
						end
						KIND_PUSH: begin
							cmd.push      = 1'b1;
							cmd.status_ld = 1'b1;
						end
						KIND_RESERVE: begin
							cmd.reserve   = 1'b1;
							cmd.status_ld = 1'b1;
						end
						KIND_POP: begin
							cmd.pop_start = 1'b1;
							if (len_zero) begin
								cmd.status_ld = 1'b1;
							end else begin
								state_d = ST_POP;
							end
						end
						KIND_CLEAR: begin
							cmd.clear     = 1'b1;
							cmd.status_ld = 1'b1;
						end
						default: begin
							cmd.status_ld = 1'b1;
						end
					endcase
				end
			end
			ST_BACK: begin
				if (out_free) begin
					cmd.back_fin  = 1'b1;
					cmd.status_ld = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_POP: begin
				// emit one byte per free output slot; the datapath fetches the next
				if (out_free) begin
					cmd.pop_ld = 1'b1;
					if (status.pop_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.status_ld || cmd.pop_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bsfm_datapath.sv =====
// ----------------------------------------------------------------------------
// bsfm_datapath
// Stack pointer, mark count, byte and mark memories, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfm_datapath
	import bsfm_pkg::*;
#(
	parameter int STACK_BYTES = DEF_STACK_BYTES,
	parameter int MARK_DEPTH  = DEF_MARK_DEPTH,
	parameter int MAX_POP_OUT = DEF_MAX_POP_OUT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bsfm_cmd_t          cmd,
	output bsfm_status_t       status,
	input  logic [BYTE_W-1:0]  in_data_byte,
	input  logic [LEN_W-1:0]   in_length,
	input  logic               in_first_of_push,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               out_byte_valid,
	output logic               out_last,
	output logic [SIZE_W-1:0]  out_stack_size,
	output logic [DEPTH_W-1:0] out_mark_depth
);

	localparam int PW   = $clog2(STACK_BYTES + 1);
	localparam int AW   = $clog2(STACK_BYTES);
	localparam int MCW  = $clog2(MARK_DEPTH + 1);
	localparam int MAW  = $clog2(MARK_DEPTH);
	localparam int CW   = ((PW > LEN_W) ? PW : LEN_W) + 1;
	localparam int CNTW = $clog2(MAX_POP_OUT + 1);

	logic [BYTE_W-1:0] byte_mem [STACK_BYTES];
	logic [PW-1:0]     mark_mem [MARK_DEPTH];

	logic [PW-1:0]     sp_q, sp_d;
	logic [MCW-1:0]    mc_q, mc_d;
	logic [CNTW-1:0]   rem_q, rem_d;
	logic [AW-1:0]     rd_addr_q, rd_addr_d;
	logic [BYTE_W-1:0] rdata_q;
	logic [PW-1:0]     mark_rdata_q;

	logic              byte_we, byte_re, mark_we, mark_re;
	logic [AW-1:0]     wr_addr;

	logic [CW-1:0]     len_x, stack_x, sp_x, n_x, mark_x;
	logic              wrap;
	logic [PW-1:0]     base;
	logic [PW-1:0]     pop_sp;
	logic [CNTW-1:0]   pop_cnt;
	logic [AW-1:0]     rd_next;
	logic              rem_one;

	// Clip to capacity, and check for overflow
	assign len_x   = CW'(in_length);
	assign stack_x = CW'(STACK_BYTES);
	assign sp_x    = CW'(sp_q);
	assign n_x     = (len_x > stack_x) ? stack_x : len_x;
	assign wrap    = (sp_x + n_x) > stack_x;
	assign base    = wrap ? '0 : sp_q;

	assign pop_sp  = (len_x > sp_x) ? '0 : PW'(sp_x - len_x);
	assign pop_cnt = (len_x > CW'(MAX_POP_OUT)) ? CNTW'(MAX_POP_OUT) : CNTW'(len_x);
	assign rd_next = (rd_addr_q == AW'(STACK_BYTES - 1)) ? '0 : rd_addr_q + 1'b1;
	assign rem_one = (rem_q == CNTW'(1));
	assign mark_x  = CW'(mark_rdata_q);

	assign status.marks_empty = (mc_q == '0);
	assign status.pop_last    = rem_one;

	always_comb begin
		sp_d      = sp_q;
		mc_d      = mc_q;
		rem_d     = rem_q;
		rd_addr_d = rd_addr_q;
		byte_we   = 1'b0;
		byte_re   = 1'b0;
		mark_we   = 1'b0;
		mark_re   = cmd.back_rd;
		wr_addr   = sp_q[AW-1:0];
		if (cmd.mark && (mc_q < MCW'(MARK_DEPTH))) begin
			mark_we = 1'b1;
			mc_d    = mc_q + 1'b1;
		end
		if (cmd.back_zero || cmd.clear) begin
			sp_d = '0;
			mc_d = '0;
		end
		if (cmd.back_fin) begin
			mc_d = mc_q - 1'b1;
			sp_d = (mark_x > stack_x) ? '0 : mark_rdata_q;
		end
		if (cmd.push) begin
			// wrap only on the first byte of a payload; drop bytes on a full stack
			if (in_first_of_push) begin
				sp_d = base;
			end
			if (sp_d < PW'(STACK_BYTES)) begin
				byte_we = 1'b1;
				wr_addr = sp_d[AW-1:0];
				sp_d    = sp_d + 1'b1;
			end
		end
		if (cmd.reserve) begin
			sp_d = base + n_x[PW-1:0];
		end
		if (cmd.pop_start) begin
			sp_d      = pop_sp;
			rem_d     = pop_cnt;
			rd_addr_d = (pop_sp == PW'(STACK_BYTES)) ? '0 : pop_sp[AW-1:0];
			byte_re   = (pop_cnt != '0);
		end
		if (cmd.pop_ld && !rem_one) begin
			rem_d     = rem_q - 1'b1;
			rd_addr_d = rd_next;
			byte_re   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q      <= '0;
			mc_q      <= '0;
			rem_q     <= '0;
			rd_addr_q <= '0;
		end else begin
			sp_q      <= sp_d;
			mc_q      <= mc_d;
			rem_q     <= rem_d;
			rd_addr_q <= rd_addr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_we) begin
			byte_mem[wr_addr] <= in_data_byte;
		end
		if (byte_re) begin
			rdata_q <= byte_mem[rd_addr_d];
		end
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mc_q[MAW-1:0]] <= sp_q;
		end
		if (mark_re) begin
			mark_rdata_q <= mark_mem[MAW'(mc_q - 1'b1)];
		end
	end

	// Output register: status results and popped bytes
	always_ff @(posedge clk) begin
		if (cmd.status_ld || cmd.pop_ld) begin
			out_byte       <= cmd.pop_ld ? rdata_q : '0;
			out_byte_valid <= cmd.pop_ld;
			out_last       <= cmd.pop_ld ? rem_one : 1'b1;
			out_stack_size <= SIZE_W'(sp_d);
			out_mark_depth <= DEPTH_W'(mc_d);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bsfm_checker.sv =====
// ----------------------------------------------------------------------------
// bsfm_checker
// Port-level checks on the byte stack with frame marks.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfm_checker
	import bsfm_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input logic               result_valid,
	input logic               result_ready,
	input logic [BYTE_W-1:0]  result_byte,
	input logic               result_byte_valid,
	input logic               result_last,
	input logic [SIZE_W-1:0]  result_size,
	input logic [DEPTH_W-1:0] result_depth
);

	logic               pending_q;
	logic [SIZE_W-1:0]  size_hold_q;
	logic [DEPTH_W-1:0] depth_hold_q;

	// Track a pop stream that has delivered some but not all of its bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (result_valid && result_ready) begin
			pending_q <= !result_last;
		end
	end

	always_ff @(posedge clk) begin
		if (result_valid && result_ready) begin
			size_hold_q  <= result_size;
			depth_hold_q <= result_depth;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid &&
		$stable({result_byte, result_byte_valid, result_last, result_size, result_depth}))
		else $error("result changed while stalled");

	// A new request may be taken on the edge that hands off the last byte
	a_no_request_mid_pop: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |->
		!pending_q || (result_valid && result_ready && result_last))
		else $error("request taken while a pop stream is unfinished");

	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_byte_valid |-> result_last && (result_byte == '0))
		else $error("status result not single or carries a byte");

	a_pop_size_steady: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && pending_q |->
		(result_size == size_hold_q) && (result_depth == depth_hold_q) && result_byte_valid)
		else $error("pop stream changed size or depth mid-stream");

endmodule

bind byte_stack_with_frame_marks_top bsfm_checker u_bsfm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.result_byte       (result.out_byte),
	.result_byte_valid (result.byte_valid),
	.result_last       (result.last),
	.result_size       (result.stack_size),
	.result_depth      (result.mark_depth)
);

`default_nettype wire

// ===== tb/sv/bsfm_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// bsfm_tb_pkg
// Request and result types and the result scoreboard of the byte stack
// testbench. The scoreboard keeps its own copy of the byte stack and the
// mark stack and queues the results that each accepted request should cause.
// ----------------------------------------------------------------------------
package bsfm_tb_pkg;
	timeunit 1ns;
	timeprecision 1ps;

	import bsfm_pkg::*;

	// Kinds the block does not define; they only return a status result
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

	localparam int unsigned BYTES_CAP = DEF_STACK_BYTES;
	localparam int unsigned MARKS_MAX = DEF_MARK_DEPTH;
	localparam int unsigned POP_CAP   = DEF_MAX_POP_OUT;
	localparam int unsigned MAX_SHOWN = 30;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data_byte;
		logic [LEN_W-1:0]  length;
		logic              first_of_push;
	} request_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic               byte_valid;
		logic               last;
		logic [SIZE_W-1:0]  stack_size;
		logic [DEPTH_W-1:0] mark_depth;
	} outcome_t;

	class stack_scoreboard;
		bit [7:0]    store [BYTES_CAP];
		bit          written [BYTES_CAP];
		int unsigned marks [MARKS_MAX];
		int unsigned sp;
		int unsigned depth;
		outcome_t    expected_q [$];

		int unsigned errors;
		int unsigned checked;
		int unsigned popped_bytes;
		int unsigned marks_refused;
		int unsigned wraps;
		int unsigned dropped;

		function new();
			sp = 0;
			depth = 0;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// True when a pop of len bytes reads only bytes that were written
		function bit pop_is_safe(int unsigned len);
			int unsigned base;
			int unsigned cnt;
			base = (len > sp) ? 0 : sp - len;
			cnt = (len > POP_CAP) ? POP_CAP : len;
			for (int unsigned i = 0; i < cnt; i++)
				if (!written[(base + i) % BYTES_CAP])
					return 1'b0;
			return 1'b1;
		endfunction

		// Clip the length to capacity and wrap the pointer on overflow
		function int unsigned clip_len(logic [LEN_W-1:0] len);
			int unsigned n;
			n = (len > BYTES_CAP) ? BYTES_CAP : len;
			if (sp + n > BYTES_CAP) begin
				sp = 0;
				wraps++;
			end
			return n;
		endfunction

		function void add_result(bit [7:0] b, bit bv, bit fin);
			expected_q.push_back('{out_byte: b, byte_valid: bv, last: fin,
				stack_size: SIZE_W'(sp), mark_depth: DEPTH_W'(depth)});
		endfunction

		function void note(request_t r);
			int unsigned n;
			int unsigned cnt;
			case (r.kind)
				KIND_MARK: begin
					if (depth < MARKS_MAX) begin
						marks[depth] = sp;
						depth++;
					end else begin
						marks_refused++;
					end
				end
				KIND_BACK: begin
					if (depth == 0) begin
						sp = 0;
					end else begin
						depth--;
						sp = marks[depth];
						if (sp > BYTES_CAP)
							sp = 0;
					end
				end
				KIND_PUSH: begin
					if (r.first_of_push)
						n = clip_len(r.length);
					if (sp < BYTES_CAP) begin
						store[sp] = r.data_byte;
						written[sp] = 1'b1;
						sp++;
					end else begin
						dropped++;
					end
				end
				KIND_RESERVE: begin
					n = clip_len(r.length);
					sp += n;
				end
				KIND_POP: begin
					if (r.length > sp)
						sp = 0;
					else
						sp -= r.length;
					cnt = (r.length > POP_CAP) ? POP_CAP : r.length;
					if (cnt != 0) begin
						for (int unsigned i = 0; i < cnt; i++)
							add_result(store[(sp + i) % BYTES_CAP], 1'b1, i + 1 == cnt);
						popped_bytes += cnt;
						return;
					end
				end
				KIND_CLEAR: begin
					sp = 0;
					depth = 0;
				end
				default: begin
				end
			endcase
			add_result(8'h00, 1'b0, 1'b1);
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
			end
		endfunction

		function void check(outcome_t got);
			outcome_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("%0t: result with nothing expected, expected none, got %p",
						$time, got);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			compare("out_byte", want.out_byte, got.out_byte);
			compare("byte_valid", want.byte_valid, got.byte_valid);
			compare("last", want.last, got.last);
			compare("stack_size", want.stack_size, got.stack_size);
			compare("mark_depth", want.mark_depth, got.mark_depth);
		endfunction
	endclass

endpackage

// ===== tb/sv/byte_stack_with_frame_marks_top_tb.sv =====
// ----------------------------------------------------------------------------
// byte_stack_with_frame_marks_top_tb
// Drives requests into the byte stack with frame marks and checks every
// result against a scoreboard that tracks both stacks. A directed part hits
// the corner cases, a mark phase fills the mark store, then random payloads,
// pops, marks, backs, reserves, clears and spare kinds run under random stalls on both sides.
// ----------------------------------------------------------------------------
module byte_stack_with_frame_marks_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bsfm_pkg::*;
	import bsfm_tb_pkg::*;

	localparam int unsigned RUN_ITEMS    = 30;
	localparam int unsigned CALM_TAIL    = 10;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned CYCLE_LIMIT  = 1000000;

	logic clk = 1'b0;
	logic arst_n;

	bsfm_item_if   req_if ();
	bsfm_result_if res_if ();

	byte_stack_with_frame_marks_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (req_if),
		.result (res_if)
	);

	stack_scoreboard sb = new();

	bit          calm = 1'b0;
	bit          long_hold = 1'b0;
	int unsigned cycles = 0;
	int unsigned sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("byte_stack_with_frame_marks_top_tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check('{out_byte: res_if.out_byte, byte_valid: res_if.byte_valid,
				last: res_if.last, stack_size: res_if.stack_size,
				mark_depth: res_if.mark_depth});
	end

	// Result side: random stall bursts, one long hold-off on request
	initial begin
		int unsigned stall;
		stall = 0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				stall--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				res_if.ready <= 1'b0;
				stall = $urandom_range(1, 5) - 1;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	function automatic request_t make_request(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] d,
		logic [LEN_W-1:0] len, logic first);
		request_t r;
		r.kind = k;
		r.data_byte = d;
		r.length = len;
		r.first_of_push = first;
		return r;
	endfunction

	function automatic request_t any_request(logic [KIND_W-1:0] k);
		return make_request(k, BYTE_W'($urandom_range(0, 255)),
			LEN_W'($urandom_range(0, 17'h1FFFF)), 1'($urandom_range(0, 1)));
	endfunction

	// Offer one request, with an occasional gap ahead of it; note it on acceptance
	task automatic send(request_t r);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_if.valid         <= 1'b1;
		req_if.kind          <= r.kind;
		req_if.data_byte     <= r.data_byte;
		req_if.length        <= r.length;
		req_if.first_of_push <= r.first_of_push;
		do
			@(posedge clk);
		while (!req_if.ready);
		sb.note(r);
		sent++;
	endtask

	task automatic push_payload(int unsigned n, int unsigned declared);
		request_t r;
		for (int unsigned i = 0; i < n; i++) begin
			r = any_request(KIND_PUSH);
			r.first_of_push = (i == 0);
			if (i == 0)
				r.length = LEN_W'(declared);
			send(r);
		end
	endtask

	// Fall back to an empty pop when the bytes it would read were never written
	task automatic pop_bytes(int unsigned len);
		request_t r;
		r = any_request(KIND_POP);
		r.length = sb.pop_is_safe(len) ? LEN_W'(len) : '0;
		send(r);
	endtask

	task automatic directed_checks();
		send(make_request(KIND_BACK, 8'h00, '0, 1'b0));          // back with no mark
		send(make_request(KIND_POP, 8'hFF, '0, 1'b1));           // pop of nothing
		send(make_request(KIND_SPARE_LO, 8'hFF, 17'h1FFFF, 1'b1));
		send(make_request(KIND_SPARE_HI, 8'h00, '0, 1'b0));
		send(make_request(KIND_MARK, 8'h00, '0, 1'b0));
		send(make_request(KIND_PUSH, 8'h00, 17'd3, 1'b1));
		send(make_request(KIND_PUSH, 8'hFF, 17'h1FFFF, 1'b0));
		send(make_request(KIND_PUSH, 8'hA5, '0, 1'b0));
		send(make_request(KIND_MARK, 8'h00, '0, 1'b0));
		send(make_request(KIND_RESERVE, 8'h00, '0, 1'b1));
		send(make_request(KIND_POP, 8'h00, 17'd2, 1'b0));
		send(make_request(KIND_BACK, 8'h00, '0, 1'b0));
		send(make_request(KIND_POP, 8'h00, 17'd3, 1'b0));
		send(make_request(KIND_BACK, 8'h00, '0, 1'b0));
		// fill the stack to capacity, then push into it
		send(make_request(KIND_RESERVE, 8'h00, 17'h10000, 1'b0));
		send(make_request(KIND_PUSH, 8'h5A, 17'd5, 1'b0));
		send(make_request(KIND_PUSH, 8'h3C, '0, 1'b1));
		send(make_request(KIND_MARK, 8'h00, '0, 1'b0));
		send(make_request(KIND_PUSH, 8'hC3, 17'd1, 1'b1));       // overflow wraps to zero
		send(make_request(KIND_BACK, 8'h00, '0, 1'b0));           // back to a full stack
		send(make_request(KIND_RESERVE, 8'h00, 17'h1FFFF, 1'b1)); // clipped, wraps
		send(make_request(KIND_CLEAR, 8'hFF, 17'h1FFFF, 1'b1));
		send(make_request(KIND_PUSH, 8'h81, 17'h10000, 1'b1));
		send(make_request(KIND_POP, 8'h00, 17'd1, 1'b0));
	endtask

	task automatic random_step();
		int unsigned pick;
		int unsigned n;
		int unsigned declared;
		request_t    r;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			case ($urandom_range(0, 5))
				0: declared = $urandom_range(0, 17'h1FFFF);
				1: declared = n + $urandom_range(0, 3);
				default: declared = n;
			endcase
			push_payload(n, declared);
		end else if (pick < 50) begin
			case ($urandom_range(0, 3))
				0: pop_bytes($urandom_range(0, 8));
				1: pop_bytes($urandom_range(0, sb.sp > 17'h1FFFF ? 17'h1FFFF : sb.sp));
				2: pop_bytes($urandom_range(0, 17'h1FFFF));
				default: pop_bytes(sb.sp);
			endcase
		end else if (pick < 60) begin
			send(any_request(KIND_MARK));
		end else if (pick < 70) begin
			send(any_request(KIND_BACK));
		end else if (pick < 80) begin
			r = any_request(KIND_RESERVE);
			if ($urandom_range(0, 9) != 0)
				r.length = LEN_W'($urandom_range(0, 10));
			send(r);
		end else if (pick < 84) begin
			send(any_request(KIND_CLEAR));
		end else if (pick < 88) begin
			send(any_request($urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI));
		end else begin
			// lone push byte outside a payload
			send(any_request(KIND_PUSH));
		end
	endtask

	initial begin
		int unsigned base;
		req_if.valid = 1'b0;
		req_if.kind = KIND_MARK;
		req_if.data_byte = '0;
		req_if.length = '0;
		req_if.first_of_push = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_checks();

		// write the low bytes so that large pops read known data
		send(any_request(KIND_CLEAR));
		push_payload(64, 64);

		// fill the mark store and send marks past it, then backs, under a long result hold-off
		long_hold = 1'b1;
		while (sb.depth < MARKS_MAX)
			send(any_request(KIND_MARK));
		repeat (3) send(any_request(KIND_MARK));
		repeat (8) send(any_request(KIND_BACK));

		// hold the requests until every result is back
		req_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);

		base = sent;
		while (sent < base + RUN_ITEMS) begin
			if (sent >= base + RUN_ITEMS - CALM_TAIL)
				calm = 1'b1;
			random_step();
		end
		req_if.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests, %0d results checked, %0d bytes popped",
			sent, sb.checked, sb.popped_bytes);
		$display("%0d overflow wraps, %0d pushes into a full stack, %0d marks refused",
			sb.wraps, sb.dropped, sb.marks_refused);
		if (sb.errors == 0) begin
			$display("byte_stack_with_frame_marks_top_tb: clean");
		end else begin
			$display("byte_stack_with_frame_marks_top_tb: errors");
		end
		$finish;
	end

endmodule
